// ----- sv/wct_pkg.sv -----
// ============================================================================
// wct_pkg
// Shared types and constants for the wash-cycle countdown timer: phase and
// motor command codes, event codes, register indexes and the control bundle.
// ============================================================================
`default_nettype none

package wct_pkg;

    // Cycle phase kept between events
    typedef enum logic [1:0] {
        PH_STOPPED = 2'd0,
        PH_RUNNING = 2'd1,
        PH_PAUSED  = 2'd2
    } phase_t;

    // Motor driver commands
    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_UP   = 2'd1,
        CMD_DOWN = 2'd2,
        CMD_REV  = 2'd3
    } motor_cmd_t;

    // Event kinds on the input channel
    typedef enum logic [1:0] {
        EV_TICK   = 2'd0,
        EV_BUTTON = 2'd1,
        EV_STOP   = 2'd2
    } event_t;

    // Cycle mode codes
    localparam logic [1:0] MODE_CLEAN = 2'd0;
    localparam logic [1:0] MODE_RINSE = 2'd1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAN_SEC  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RINSE_SEC  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPIN_SEC   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AGITATE    = 3'd4;

    // Widths and display constants
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned AGIT_W = 12;
    localparam int unsigned MIN_W = 10;
    localparam int unsigned SEC_W = 6;
    localparam int unsigned STEP_W = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = 4'd15;
    localparam logic [SEC_W:0] SEC_PER_MIN = 7'd60;
    localparam logic [COUNT_W-1:0] MAX_MINUTES = 16'd999;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Reciprocal of sixty scaled by 2^21; exact for every 16-bit count
    localparam int unsigned MQ_W = 11;
    localparam int unsigned MIN_SHIFT = 21;
    localparam logic [COUNT_W-1:0] MIN_RECIP = 16'd34953;

    // Reset values of the configuration registers
    localparam logic [1:0] MODE_RESET = 2'd0;
    localparam logic [COUNT_W-1:0] DURATION_RESET = 16'd60;
    localparam logic [AGIT_W-1:0] AGITATE_RESET = 12'd5;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // apply the event and load the divider
        logic step;      // one bit of the interval division
        logic load_out;  // move the finished result into the output register
    } dp_cmd_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DIVIDE = 2'd1,
        ST_RESULT = 2'd2
    } ctrl_state_t;

endpackage : wct_pkg

`default_nettype wire

// ----- sv/wct_ctrl.sv -----
// ============================================================================
// wct_ctrl
// Controller for the wash-cycle timer: takes one event, runs the 16-step
// bit-serial division, then hands the result to the output register.
// ============================================================================
`default_nettype none

module wct_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output wct_pkg::dp_cmd_t      dp_cmd
);
    import wct_pkg::*;

    ctrl_state_t        state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               out_valid_reg, out_valid_next;

    // State, step counter and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        dp_cmd          = '0;
        in_ready        = 1'b0;
        out_valid_next  = out_valid_reg;

        // Drop valid once the result transfer completes
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.accept = 1'b1;
                    step_next     = '0;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                dp_cmd.step = 1'b1;
                step_next   = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    dp_cmd.load_out = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // An accepted event always starts a fresh division
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DIVIDE && step_reg == '0))
        else $error("accepted event did not start the division");

    // The last division step leads to the result state
    a_divide_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE && step_reg == LAST_STEP) |=> (state_reg == ST_RESULT))
        else $error("division did not end after the last step");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output register loaded while a result was waiting");

    // No new event while one is still in the division
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second event accepted during processing");
`endif

endmodule : wct_ctrl

`default_nettype wire

// ----- sv/wct_dp.sv -----
// ============================================================================
// wct_dp
// Datapath for the wash-cycle timer: configuration registers, phase and
// remaining count, the event update, a bit-serial remainder of the count by
// the agitate interval, a reciprocal minute split, and the output register.
// ============================================================================
`default_nettype none

module wct_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire wct_pkg::dp_cmd_t                  dp_cmd,
    input  wire logic                              cfg_write,
    input  wire logic [wct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [wct_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [1:0]                        func,
    input  wire logic                              motor_running,
    output logic [1:0]                             motor_command,
    output logic [1:0]                             run_state,
    output logic [wct_pkg::MIN_W-1:0]              minutes_left,
    output logic [wct_pkg::SEC_W-1:0]              seconds_left,
    output logic                                   time_shown,
    output logic                                   cycle_done
);
    import wct_pkg::*;

    // Configuration registers
    logic [1:0]          mode_reg;
    logic [COUNT_W-1:0]  clean_reg;
    logic [COUNT_W-1:0]  rinse_reg;
    logic [COUNT_W-1:0]  spin_reg;
    logic [AGIT_W-1:0]   agit_reg;

    // Block state
    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    // Per-event working registers
    motor_cmd_t          cmd_reg, cmd_next;
    logic                done_reg, done_next;
    logic                blank_reg, blank_next;
    logic                rev_cand_reg, rev_cand_next;
    logic [COUNT_W-1:0]  dvd_reg;
    logic [AGIT_W-1:0]   rem_a_reg;
    logic [MQ_W-1:0]     min_quot_reg;
    logic [SEC_W-1:0]    rem_m_reg;

    // Output register
    logic [1:0]          motor_command_reg;
    logic [1:0]          run_state_reg;
    logic [MIN_W-1:0]    minutes_left_reg;
    logic [SEC_W-1:0]    seconds_left_reg;
    logic                time_shown_reg;
    logic                cycle_done_reg;

    phase_t              cur_phase;
    logic [COUNT_W-1:0]  duration;
    logic [COUNT_W-1:0]  load_count;
    logic [COUNT_W-1:0]  dec_count;
    logic                agit_mode;

    logic                div_bit;
    logic [AGIT_W:0]     sh_a;
    logic                ge_a;
    logic [AGIT_W:0]     diff_a;

    logic [2*COUNT_W-1:0] min_prod;
    logic [COUNT_W-1:0]  min_back;
    logic [COUNT_W-1:0]  min_rem;

    logic                rev_hit;
    motor_cmd_t          cmd_final;
    logic                shown;
    logic [MIN_W-1:0]    mins_sat;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            clean_reg <= DURATION_RESET;
            rinse_reg <= DURATION_RESET;
            spin_reg  <= DURATION_RESET;
            agit_reg  <= AGITATE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CYCLE_MODE: mode_reg  <= cfg_data[1:0];
                REG_CLEAN_SEC:  clean_reg <= cfg_data;
                REG_RINSE_SEC:  rinse_reg <= cfg_data;
                REG_SPIN_SEC:   spin_reg  <= cfg_data;
                REG_AGITATE:    agit_reg  <= cfg_data[AGIT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Selected duration plus one, saturated
    always_comb
    begin
        unique case (mode_reg)
            MODE_CLEAN: duration = clean_reg;
            MODE_RINSE: duration = rinse_reg;
            default:    duration = spin_reg;
        endcase
        load_count = (duration == COUNT_MAX) ? COUNT_MAX : duration + 1'b1;
        dec_count  = (count_reg == '0) ? '0 : count_reg - 1'b1;
        agit_mode  = (mode_reg == MODE_CLEAN || mode_reg == MODE_RINSE) && (agit_reg != '0);
    end

    // Apply one event to phase and count
    always_comb
    begin
        unique case (phase_reg)
            PH_RUNNING: cur_phase = PH_RUNNING;
            PH_PAUSED:  cur_phase = PH_PAUSED;
            default:    cur_phase = PH_STOPPED;
        endcase

        phase_next    = cur_phase;
        count_next    = count_reg;
        cmd_next      = CMD_NONE;
        done_next     = 1'b0;
        blank_next    = 1'b0;
        rev_cand_next = 1'b0;

        unique case (func)
            EV_TICK:
            begin
                if (cur_phase == PH_RUNNING)
                begin
                    count_next = dec_count;
                    if (dec_count == '0)
                    begin
                        cmd_next   = CMD_DOWN;
                        phase_next = PH_STOPPED;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        rev_cand_next = agit_mode && motor_running;
                    end
                end
            end
            EV_BUTTON:
            begin
                unique case (cur_phase)
                    PH_RUNNING:
                    begin
                        phase_next = PH_PAUSED;
                        cmd_next   = CMD_DOWN;
                    end
                    PH_PAUSED:
                    begin
                        phase_next = PH_RUNNING;
                        cmd_next   = CMD_UP;
                    end
                    default:
                    begin
                        count_next = load_count;
                        phase_next = PH_RUNNING;
                        cmd_next   = CMD_UP;
                        blank_next = 1'b1;
                    end
                endcase
            end
            EV_STOP:
            begin
                if (cur_phase != PH_STOPPED)
                begin
                    phase_next = PH_STOPPED;
                    count_next = '0;
                    cmd_next   = CMD_DOWN;
                end
            end
            default:
            begin
                // Unused event code: nothing changes
            end
        endcase
    end

    // Phase and count registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_STOPPED;
            count_reg <= '0;
        end
        else if (dp_cmd.accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // One restoring-division step of the count by the agitate interval
    always_comb
    begin
        div_bit = dvd_reg[COUNT_W-1];
        sh_a    = {rem_a_reg, div_bit};
        ge_a    = sh_a >= {1'b0, agit_reg};
        diff_a  = sh_a - {1'b0, agit_reg};
    end

    // Minutes by reciprocal multiply, seconds by taking sixty per minute back off
    always_comb
    begin
        min_prod = {{COUNT_W{1'b0}}, count_reg} * {{COUNT_W{1'b0}}, MIN_RECIP};
        min_back = {{(COUNT_W-MQ_W){1'b0}}, min_quot_reg}
                   * {{(COUNT_W-SEC_W-1){1'b0}}, SEC_PER_MIN};
        min_rem  = count_reg - min_back;
    end

    // Event scratch and divider registers; the minute split settles after two steps
    always_ff @(posedge clk)
    begin
        if (dp_cmd.accept)
        begin
            cmd_reg      <= cmd_next;
            done_reg     <= done_next;
            blank_reg    <= blank_next;
            rev_cand_reg <= rev_cand_next;
            dvd_reg      <= count_next;
            rem_a_reg    <= '0;
            rem_m_reg    <= '0;
        end
        else if (dp_cmd.step)
        begin
            dvd_reg      <= {dvd_reg[COUNT_W-2:0], 1'b0};
            rem_a_reg    <= ge_a ? diff_a[AGIT_W-1:0] : sh_a[AGIT_W-1:0];
            min_quot_reg <= min_prod[MIN_SHIFT +: MQ_W];
            rem_m_reg    <= min_rem[SEC_W-1:0];
        end
    end

    // Resolve the reversal and the display fields
    always_comb
    begin
        rev_hit   = rev_cand_reg && (rem_a_reg == '0)
                    && (count_reg >= {{(COUNT_W-AGIT_W){1'b0}}, agit_reg});
        cmd_final = rev_hit ? CMD_REV : cmd_reg;
        shown     = !blank_reg && (phase_reg != PH_STOPPED) && (count_reg != '0);
        mins_sat  = ({{(COUNT_W-MQ_W){1'b0}}, min_quot_reg} > MAX_MINUTES)
                    ? MAX_MINUTES[MIN_W-1:0] : min_quot_reg[MIN_W-1:0];
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_out)
        begin
            motor_command_reg <= cmd_final;
            run_state_reg     <= phase_reg;
            minutes_left_reg  <= shown ? mins_sat : '0;
            seconds_left_reg  <= shown ? rem_m_reg : '0;
            time_shown_reg    <= shown;
            cycle_done_reg    <= done_reg;
        end
    end

    assign motor_command = motor_command_reg;
    assign run_state     = run_state_reg;
    assign minutes_left  = minutes_left_reg;
    assign seconds_left  = seconds_left_reg;
    assign time_shown    = time_shown_reg;
    assign cycle_done    = cycle_done_reg;

endmodule : wct_dp

`default_nettype wire

// ----- sv/wash_cycle_timer.sv -----
// Each event passes the accept state, 16 steps of the bit-serial remainder of
// the count by the agitate interval, and the result load; no new event is taken
// before that result load.
// An event is taken while a result waits; its own load then waits for out_ready.
// Reset (rst_n low, asynchronous): phase stopped, count zero, registers at
// their defaults (clean mode, 60 s durations, 5 s agitate interval).
// ============================================================================
// wash_cycle_timer
// Wash-cycle countdown controller: start/pause/stop handling, per-second
// countdown, motor ramp and reversal commands, minute/second display.
// ============================================================================
`default_nettype none

module wash_cycle_timer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [wct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [wct_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        func,
    input  wire logic                              motor_running,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [1:0]                             motor_command,
    output logic [1:0]                             run_state,
    output logic [wct_pkg::MIN_W-1:0]              minutes_left,
    output logic [wct_pkg::SEC_W-1:0]              seconds_left,
    output logic                                   time_shown,
    output logic                                   cycle_done
);
    import wct_pkg::*;

    dp_cmd_t dp_cmd;

    // Sequence control
    wct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd)
    );

    // State, arithmetic and result register
    wct_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .func          (func),
        .motor_running (motor_running),
        .motor_command (motor_command),
        .run_state     (run_state),
        .minutes_left  (minutes_left),
        .seconds_left  (seconds_left),
        .time_shown    (time_shown),
        .cycle_done    (cycle_done)
    );

endmodule : wash_cycle_timer

`default_nettype wire

// ----- verif/wash_cycle_timer_tb.sv -----
// ============================================================================
// wash_cycle_timer_tb
// Self-checking bench for the wash-cycle countdown timer. Events go in over a
// valid/ready channel, a scoreboard predicts the state, motor command and
// display for each one, and every result transfer is checked against it.
// ============================================================================

module wash_cycle_timer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wct_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [1:0] EV_UNUSED   = 2'd3;
    localparam logic [1:0] MODE_SPIN   = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int unsigned CYCLE_LIMIT     = 500000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES   = 24;
    localparam int unsigned PHASES          = 10;
    localparam int unsigned PHASE_ITEMS     = 150;

    typedef struct {
        motor_cmd_t       cmd;
        phase_t           state;
        logic [MIN_W-1:0] mins;
        logic [SEC_W-1:0] secs;
        logic             shown;
        logic             done;
    } display_t;

    // Countdown scoreboard: own copy of registers and state, queue of
    // expected displays in transfer order
    class countdown_scoreboard;
        logic [1:0]         mode      = MODE_RESET;
        logic [COUNT_W-1:0] clean_sec = DURATION_RESET;
        logic [COUNT_W-1:0] rinse_sec = DURATION_RESET;
        logic [COUNT_W-1:0] spin_sec  = DURATION_RESET;
        logic [AGIT_W-1:0]  agitate   = AGITATE_RESET;
        phase_t             ph        = PH_STOPPED;
        logic [COUNT_W-1:0] count     = '0;
        display_t           pending_q[$];
        int unsigned n_events, n_checked, n_finished, n_reversals;
        int unsigned n_pauses, n_saturated, n_writes, mismatches;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CYCLE_MODE: mode = data[1:0];
                REG_CLEAN_SEC:  clean_sec = data;
                REG_RINSE_SEC:  rinse_sec = data;
                REG_SPIN_SEC:   spin_sec = data;
                REG_AGITATE:    agitate = data[AGIT_W-1:0];
                default: ;
            endcase
            n_writes++;
        endfunction

        // Apply one accepted event and queue the display it produces
        function void note_event(logic [1:0] f, logic motor_on);
            display_t           d;
            logic               blank;
            logic [COUNT_W-1:0] dur;
            int unsigned        loaded;
            int unsigned        mins;
            d.cmd  = CMD_NONE;
            d.done = 1'b0;
            blank  = 1'b0;
            if (ph != PH_RUNNING && ph != PH_PAUSED)
                ph = PH_STOPPED;
            case (f)
                EV_TICK:
                begin
                    if (ph == PH_RUNNING)
                    begin
                        if (count != 0)
                            count = count - 1'b1;
                        if ((mode == MODE_CLEAN || mode == MODE_RINSE) && agitate != 0 &&
                            (count % agitate) == 0 && count >= agitate && motor_on)
                        begin
                            d.cmd = CMD_REV;
                            n_reversals++;
                        end
                        if (count == 0)
                        begin
                            d.cmd  = CMD_DOWN;
                            ph     = PH_STOPPED;
                            d.done = 1'b1;
                            n_finished++;
                        end
                    end
                end
                EV_BUTTON:
                begin
                    if (ph == PH_STOPPED)
                    begin
                        case (mode)
                            MODE_CLEAN: dur = clean_sec;
                            MODE_RINSE: dur = rinse_sec;
                            default:    dur = spin_sec;
                        endcase
                        loaded = 32'(dur) + 1;
                        count  = (loaded > COUNT_MAX) ? COUNT_MAX : loaded[COUNT_W-1:0];
                        ph     = PH_RUNNING;
                        d.cmd  = CMD_UP;
                        blank  = 1'b1;
                    end
                    else if (ph == PH_RUNNING)
                    begin
                        ph    = PH_PAUSED;
                        d.cmd = CMD_DOWN;
                        n_pauses++;
                    end
                    else
                    begin
                        ph    = PH_RUNNING;
                        d.cmd = CMD_UP;
                    end
                end
                EV_STOP:
                begin
                    if (ph != PH_STOPPED)
                    begin
                        ph    = PH_STOPPED;
                        count = '0;
                        d.cmd = CMD_DOWN;
                    end
                end
                default: ;
            endcase
            d.state = ph;
            d.shown = !blank && ph != PH_STOPPED && count != 0;
            mins = count / SEC_PER_MIN;
            if (mins > MAX_MINUTES)
            begin
                mins = MAX_MINUTES;
                if (d.shown)
                    n_saturated++;
            end
            d.mins = d.shown ? mins[MIN_W-1:0] : '0;
            d.secs = d.shown ? SEC_W'(count % SEC_PER_MIN) : '0;
            n_events++;
            pending_q.push_back(d);
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        // Match one result transfer against the oldest expected display
        function void check_display(logic [1:0] cmd, logic [1:0] st, logic [MIN_W-1:0] mins,
                                    logic [SEC_W-1:0] secs, logic shown, logic done);
            display_t want;
            if (pending_q.size() == 0)
            begin
                $display("%0t: result with no event pending, expected none, actual cmd %0d state %0d",
                         $time, cmd, st);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            n_checked++;
            compare("motor_command", want.cmd, cmd);
            compare("run_state", want.state, st);
            compare("minutes_left", want.mins, mins);
            compare("seconds_left", want.secs, secs);
            compare("time_shown", want.shown, shown);
            compare("cycle_done", want.done, done);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            func;
    logic                  motor_running;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            motor_command;
    logic [1:0]            run_state;
    logic [MIN_W-1:0]      minutes_left;
    logic [SEC_W-1:0]      seconds_left;
    logic                  time_shown;
    logic                  cycle_done;

    logic        in_took = 1'b0;
    bit          hold_req;
    int unsigned cycle_count = 0;

    countdown_scoreboard model = new;

    wash_cycle_timer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .motor_running (motor_running),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .motor_command (motor_command),
        .run_state     (run_state),
        .minutes_left  (minutes_left),
        .seconds_left  (seconds_left),
        .time_shown    (time_shown),
        .cycle_done    (cycle_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Sample both channels at the rising edge
    always @(posedge clk)
    begin
        in_took <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                model.note_event(func, motor_running);
            if (out_valid && out_ready)
                model.check_display(motor_command, run_state, minutes_left, seconds_left,
                                    time_shown, cycle_done);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, model.pending_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: stall in segments of varying style, with one long hold-off
    initial
    begin
        int unsigned style;
        int unsigned span;
        int unsigned k;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(10, 250);
            for (k = 0; k < span; k++)
            begin
                @(negedge clk);
                if (hold_req)
                begin
                    out_ready <= 1'b0;
                    hold_req = 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(negedge clk);
                end
                else
                begin
                    case (style)
                        0: out_ready <= 1'b1;
                        1: out_ready <= 1'($urandom_range(0, 1));
                        2: out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= ((k % 7) < 3);
                    endcase
                end
            end
        end
    end

    // Offer one event and hold it until its transfer
    task automatic send_event(input logic [1:0] f, input logic m);
        func          <= f;
        motor_running <= m;
        in_valid      <= 1'b1;
        do
            @(negedge clk);
        while (!in_took);
    endtask

    task automatic idle_gap(input int unsigned n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_write <= 1'b1;
        model.set_reg(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected display has come out
    task automatic drain();
        in_valid <= 1'b0;
        while (model.pending_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly short durations so cycles run out; now and then the extremes
    function automatic logic [15:0] pick_duration();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 16'($urandom_range(1, 20));
        else if (r < 90)
            return 16'($urandom_range(21, 400));
        else if (r < 95)
            return 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 3))
            0: return 16'd0;
            1: return 16'd59940;
            2: return 16'd65534;
            default: return 16'd65535;
        endcase
    endfunction

    initial
    begin
        int unsigned p;
        int unsigned i;
        int unsigned j;
        int unsigned blen;
        int unsigned r;
        logic [1:0]  f;
        logic [1:0]  mode;
        logic [11:0] agit;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        func          = EV_TICK;
        motor_running = 1'b0;
        hold_req      = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: idle events, start, reversal, pause, resume, abort
        send_event(EV_STOP, 1'b0);
        send_event(EV_TICK, 1'b1);
        send_event(EV_UNUSED, 1'b1);
        send_event(EV_BUTTON, 1'b1);
        send_event(EV_TICK, 1'b1);
        send_event(EV_TICK, 1'b0);
        send_event(EV_BUTTON, 1'b1);
        send_event(EV_TICK, 1'b1);
        send_event(EV_BUTTON, 1'b0);
        send_event(EV_STOP, 1'b1);
        drain();

        // Shortest clean cycle with unit interval: reverse on the last second, then end
        program_reg(REG_CYCLE_MODE, MODE_CLEAN);
        program_reg(REG_CLEAN_SEC, 16'd1);
        program_reg(REG_AGITATE, 12'd1);
        send_event(EV_BUTTON, 1'b1);
        send_event(EV_TICK, 1'b1);
        send_event(EV_TICK, 1'b1);
        drain();

        // Unused mode acts as spin; load saturates and minutes clip
        program_reg(REG_CYCLE_MODE, MODE_UNUSED);
        program_reg(REG_SPIN_SEC, 16'hFFFF);
        send_event(EV_BUTTON, 1'b1);
        send_event(EV_TICK, 1'b1);
        send_event(EV_STOP, 1'b0);
        drain();

        // Zero spin duration ends on the first tick
        program_reg(REG_CYCLE_MODE, MODE_SPIN);
        program_reg(REG_SPIN_SEC, 16'd0);
        send_event(EV_BUTTON, 1'b0);
        send_event(EV_TICK, 1'b1);
        drain();

        // Zero interval never reverses
        program_reg(REG_CYCLE_MODE, MODE_RINSE);
        program_reg(REG_RINSE_SEC, 16'd59940);
        program_reg(REG_AGITATE, 12'd0);
        send_event(EV_BUTTON, 1'b1);
        send_event(EV_TICK, 1'b1);
        send_event(EV_STOP, 1'b1);
        drain();

        // One-hour interval in rinse, then stop from paused
        program_reg(REG_RINSE_SEC, 16'd7200);
        program_reg(REG_AGITATE, 12'd3600);
        send_event(EV_BUTTON, 1'b1);
        send_event(EV_TICK, 1'b1);
        send_event(EV_BUTTON, 1'b1);
        send_event(EV_STOP, 1'b0);
        drain();

        // Random phases, each with a fresh register setup
        for (p = 0; p < PHASES; p++)
        begin
            r = $urandom_range(0, 99);
            mode = (r < 30) ? MODE_CLEAN : (r < 60) ? MODE_RINSE :
                   (r < 90) ? MODE_SPIN : MODE_UNUSED;
            r = $urandom_range(0, 99);
            if (r < 70)
                agit = 12'($urandom_range(1, 6));
            else if (r < 85)
                agit = 12'($urandom_range(7, 60));
            else if (r < 92)
                agit = 12'd0;
            else if (r < 96)
                agit = 12'($urandom_range(0, 4095));
            else
                agit = ($urandom_range(0, 1) != 0) ? 12'd3600 : 12'd4095;
            program_reg(REG_CYCLE_MODE, mode);
            program_reg(REG_CLEAN_SEC, pick_duration());
            program_reg(REG_RINSE_SEC, pick_duration());
            program_reg(REG_SPIN_SEC, pick_duration());
            program_reg(REG_AGITATE, agit);
            if (p == 1)
                hold_req = 1'b1;

            i = 0;
            while (i < PHASE_ITEMS)
            begin
                blen = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 10);
                for (j = 0; j < blen && i < PHASE_ITEMS; j++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 68)
                        f = EV_TICK;
                    else if (r < 84)
                        f = EV_BUTTON;
                    else if (r < 93)
                        f = EV_STOP;
                    else if (r < 97)
                        f = EV_UNUSED;
                    else
                        f = EV_BUTTON;
                    send_event(f, $urandom_range(0, 4) != 0);
                    i++;
                end
                idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30));
            end
            drain();
        end

        $display("Covered %0d events over %0d register writes, %0d results checked",
                 model.n_events, model.n_writes, model.n_checked);
        $display("%0d cycles ran out, %0d reversals, %0d pauses, %0d clipped minute displays",
                 model.n_finished, model.n_reversals, model.n_pauses, model.n_saturated);
        if (model.mismatches == 0 && model.pending_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
